>>> src/b64u_pkg.sv
`default_nettype none

package b64u_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned GroupW = 3 * ByteW;
    localparam int unsigned HeldW  = 2 * ByteW;
    localparam int unsigned SixW   = 6;
    localparam int unsigned CharW  = 7;

    localparam logic [CharW-1:0] PadChar = 7'h23;

    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_ONE  = 2'd1,
        PAD_TWO  = 2'd2
    } t_pad;

    typedef struct packed {
        logic [GroupW-1:0] bits;
        t_pad              pad;
        logic              fin;
    } t_group;

    // url-safe alphabet lookup
    function automatic logic [CharW-1:0] enc_six(input logic [SixW-1:0] v);
        logic [CharW-1:0] r;
        logic [CharW-1:0] w;
        w = {1'b0, v};
        if (v < 6'd26) begin
            r = 7'h41 + w;
        end else if (v < 6'd52) begin
            r = 7'h61 + (w - 7'd26);
        end else if (v < 6'd62) begin
            r = 7'h30 + (w - 7'd52);
        end else if (v == 6'd62) begin
            r = 7'h2d;
        end else begin
            r = 7'h5f;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/b64u_front.sv
`default_nettype none

module b64u_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_accept,
    input  wire logic [b64u_pkg::ByteW-1:0]       i_data_byte,
    input  wire logic                             i_final_byte,
    output logic                                  o_q_push,
    output b64u_pkg::t_group                      o_q_data
);

    logic [b64u_pkg::HeldW-1:0] r_held;
    logic [b64u_pkg::HeldW-1:0] n_held;
    logic [1:0]                 r_count;
    logic [1:0]                 n_count;

    always_comb begin
        n_held        = r_held;
        n_count       = r_count;
        o_q_push      = 1'b0;
        o_q_data.bits = {r_held, i_data_byte};
        o_q_data.pad  = b64u_pkg::PAD_NONE;
        o_q_data.fin  = i_final_byte;
        if (i_accept) begin
            if (r_count == 2'd2) begin
                o_q_push = 1'b1;
                n_count  = 2'd0;
                n_held   = '0;
            end else if (i_final_byte) begin
                o_q_push = 1'b1;
                n_count  = 2'd0;
                n_held   = '0;
                if (r_count == 2'd1) begin
                    o_q_data.bits = {r_held[15:8], i_data_byte, 8'h00};
                    o_q_data.pad  = b64u_pkg::PAD_ONE;
                end else begin
                    o_q_data.bits = {i_data_byte, 16'h0000};
                    o_q_data.pad  = b64u_pkg::PAD_TWO;
                end
            end else if (r_count == 2'd1) begin
                n_held  = {r_held[15:8], i_data_byte};
                n_count = 2'd2;
            end else begin
                n_held  = {i_data_byte, 8'h00};
                n_count = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_count <= 2'd0;
        end else begin
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> src/b64u_queue.sv
`default_nettype none

module b64u_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire b64u_pkg::t_group i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output b64u_pkg::t_group      o_head
);

    b64u_pkg::t_group r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/b64u_back.sv
`default_nettype none

module b64u_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire b64u_pkg::t_group                 i_q_head,
    input  wire logic                             i_q_empty,
    output logic                                  o_q_pop,
    input  wire logic                             i_pop,
    output logic                                  o_empty,
    output logic [b64u_pkg::CharW-1:0]            o_out_char,
    output logic                                  o_last_char
);

    logic [1:0]                 r_idx;
    logic                       r_valid;
    logic [b64u_pkg::CharW-1:0] r_char;
    logic                       r_last;
    logic                       w_adv;
    logic                       w_load;
    logic [b64u_pkg::SixW-1:0]  w_six;
    logic                       w_is_pad;
    logic [b64u_pkg::CharW-1:0] w_char;

    assign w_adv   = !r_valid || i_pop;
    assign w_load  = w_adv && !i_q_empty;
    assign o_q_pop = w_load && (r_idx == 2'd3);

    always_comb begin
        case (r_idx)
            2'd0:    w_six = i_q_head.bits[23:18];
            2'd1:    w_six = i_q_head.bits[17:12];
            2'd2:    w_six = i_q_head.bits[11:6];
            default: w_six = i_q_head.bits[5:0];
        endcase
        w_is_pad = ((i_q_head.pad == b64u_pkg::PAD_TWO) && r_idx[1])
                || ((i_q_head.pad == b64u_pkg::PAD_ONE) && (r_idx == 2'd3));
        w_char   = w_is_pad ? b64u_pkg::PadChar : b64u_pkg::enc_six(w_six);
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char <= w_char;
            r_last <= i_q_head.fin && (r_idx == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_valid <= !i_q_empty;
            end
            if (w_load) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    assign o_empty     = !r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule

`default_nettype wire

>>> src/base64url_stream_encoder.sv
// Streaming base64url encoder. Bytes go in one word per cycle through push/full
// while full is low; every three bytes, or a byte marked final, close a group
// that becomes four characters of A-Z a-z 0-9 - _, with '#' standing in for the
// one or two characters past the end of a short final group. Characters come out
// one word per cycle through empty/pop while pop is high and empty is low, and
// last_char marks the fourth character of the group closed by a final byte. The
// character unit produces one character per cycle unless pop or an empty queue
// holds it, so sustained input is three bytes per four characters out; a
// two-entry group queue lets input run ahead by up to two groups. A closing byte
// writes its group into the queue; the first character is registered from there.
`default_nettype none

module base64url_stream_encoder (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [b64u_pkg::ByteW-1:0]       i_data_byte,
    input  wire logic                             i_final_byte,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [b64u_pkg::CharW-1:0]            o_out_char,
    output logic                                  o_last_char
);

    logic             w_accept;
    logic             w_q_push;
    logic             w_q_pop;
    logic             w_q_full;
    logic             w_q_empty;
    b64u_pkg::t_group w_q_in;
    b64u_pkg::t_group w_q_head;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    b64u_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_q_push     (w_q_push),
        .o_q_data     (w_q_in)
    );

    b64u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    b64u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_head    (w_q_head),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("group written into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("group retired from empty queue");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_char) && $stable(o_last_char)))
        else $error("waiting word changed");

endmodule

`default_nettype wire

>>> tb/base64url_stream_encoder_test.sv
`timescale 1ns / 100ps

module base64url_stream_encoder_test;

    localparam int unsigned RandomBytes   = 440;
    localparam int unsigned StallLimit    = 2000;
    localparam int unsigned HoldOffCycles = 300;
    localparam int unsigned HoldOffAfter  = 120;
    localparam int unsigned DrainCycles   = 16;
    localparam int unsigned SteadyFirst   = 200;
    localparam int unsigned SteadyLast    = 300;
    localparam int unsigned NumRows       = 23;
    localparam int unsigned ReportMax     = 10;

    localparam logic [8*64-1:0] Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    typedef struct packed {
        logic [b64u_pkg::CharW-1:0] ch;
        logic                       last;
    } t_char;

    // chars: four ascii codes typed in, or zero to take the encoding as computed
    typedef struct packed {
        logic [b64u_pkg::ByteW-1:0] data;
        logic                       fin;
        logic [31:0]                chars;
    } t_row;

    localparam t_row DirRows [NumRows] = '{
        '{8'h00, 1'b1, "AA##"},
        '{8'hff, 1'b1, "_w##"},
        '{8'h00, 1'b0, 32'h0},
        '{8'h00, 1'b0, 32'h0},
        '{8'h00, 1'b0, "AAAA"},
        '{8'hff, 1'b0, 32'h0},
        '{8'hff, 1'b0, 32'h0},
        '{8'hff, 1'b1, "____"},
        '{8'hff, 1'b0, 32'h0},
        '{8'hff, 1'b1, "__8#"},
        '{8'hfb, 1'b0, 32'h0},
        '{8'hef, 1'b0, 32'h0},
        '{8'hbe, 1'b0, "----"},
        '{8'h4d, 1'b0, 32'h0},
        '{8'h61, 1'b0, 32'h0},
        '{8'h6e, 1'b1, 32'h0},
        '{8'h4d, 1'b0, 32'h0},
        '{8'h61, 1'b1, 32'h0},
        '{8'h80, 1'b1, 32'h0},
        '{8'h01, 1'b0, 32'h0},
        '{8'h02, 1'b0, 32'h0},
        '{8'h03, 1'b0, 32'h0},
        '{8'h7f, 1'b1, 32'h0}
    };

    logic                       i_clk;
    logic                       i_rst_n      = 1'b0;
    logic                       push         = 1'b0;
    logic [b64u_pkg::ByteW-1:0] i_data_byte  = '0;
    logic                       i_final_byte = 1'b0;
    logic                       pop          = 1'b0;
    logic                       full;
    logic                       empty;
    logic [b64u_pkg::CharW-1:0] o_out_char;
    logic                       o_last_char;

    logic [2*b64u_pkg::ByteW-1:0] held_bytes = '0;
    logic [1:0]                   held_count = '0;
    t_char                        expected_chars [$];
    int unsigned                  mismatches   = 0;
    int unsigned                  chars_seen   = 0;
    int unsigned                  idle_cycles  = 0;
    bit                           steady       = 1'b0;
    bit                           held_off     = 1'b0;

    base64url_stream_encoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .empty        (empty),
        .pop          (pop),
        .o_out_char   (o_out_char),
        .o_last_char  (o_last_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= ReportMax) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // gathers one byte; a closed group queues its four characters
    task automatic encode_byte(input logic [b64u_pkg::ByteW-1:0] b, input logic fin,
                               input logic [31:0] typed);
        logic [23:0] group;
        int          pad;
        logic [5:0]  six;
        t_char       c;
        if (held_count == 2'd2) begin
            group = {held_bytes, b};
            pad   = 0;
        end else if (fin) begin
            if (held_count == 2'd1) begin
                group = {held_bytes[15:8], b, 8'h00};
                pad   = 1;
            end else begin
                group = {b, 16'h0000};
                pad   = 2;
            end
        end else begin
            if (held_count == 2'd1) begin
                held_bytes[7:0] = b;
            end else begin
                held_bytes = {b, 8'h00};
            end
            held_count = held_count + 2'd1;
            return;
        end
        for (int k = 0; k < 4; k++) begin
            six    = group[18-6*k +: 6];
            c.ch   = (k >= 4 - pad) ? b64u_pkg::PadChar
                                    : Alphabet[8*(63-six) +: b64u_pkg::CharW];
            c.last = fin && (k == 3);
            if (typed != 32'h0) begin
                c.ch = typed[24-8*k +: b64u_pkg::CharW];
            end
            expected_chars.push_back(c);
        end
        held_bytes = '0;
        held_count = '0;
    endtask

    task automatic send_byte(input logic [b64u_pkg::ByteW-1:0] b, input logic fin,
                             input logic [31:0] typed);
        while (!steady && $urandom_range(99) < 30) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (full);
        encode_byte(b, fin, typed);
    endtask

    task automatic check_char();
        t_char e;
        chars_seen++;
        if (expected_chars.size() == 0) begin
            note_mismatch($sformatf("unexpected word: char %h last %b",
                                    o_out_char, o_last_char));
        end else begin
            e = expected_chars.pop_front();
            if (o_out_char !== e.ch) begin
                note_mismatch($sformatf("out_char: expected %h, got %h", e.ch, o_out_char));
            end
            if (o_last_char !== e.last) begin
                note_mismatch($sformatf("last_char: expected %b, got %b",
                                        e.last, o_last_char));
            end
        end
    endtask

    // receiver, with one long hold-off so the input side backs up
    initial begin
        forever begin
            if (!held_off && chars_seen >= HoldOffAfter) begin
                held_off = 1'b1;
                pop <= 1'b0;
                repeat (HoldOffCycles) @(posedge i_clk);
            end
            pop <= steady || ($urandom_range(99) >= 30);
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                check_char();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("base64url_stream_encoder verification failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned sent;
        int unsigned len;
        int unsigned sel;
        bit          closed;
        logic [b64u_pkg::ByteW-1:0] b;
        sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DirRows[i]) begin
            send_byte(DirRows[i].data, DirRows[i].fin, DirRows[i].chars);
        end

        while (sent < RandomBytes) begin
            len    = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(7, 1);
            closed = ($urandom_range(9) != 0);
            for (int i = 0; i < len; i++) begin
                sel = $urandom_range(9);
                if (sel == 0) begin
                    b = 8'h00;
                end else if (sel == 1) begin
                    b = 8'hff;
                end else begin
                    b = 8'($urandom_range(255));
                end
                steady = (sent >= SteadyFirst) && (sent < SteadyLast);
                send_byte(b, closed && (i == len - 1), 32'h0);
                sent++;
            end
        end
        steady = 1'b0;
        push <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("base64url_stream_encoder verification clean");
        end else begin
            $display("base64url_stream_encoder verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/b64u_pkg.sv
src/b64u_front.sv
src/b64u_queue.sv
src/b64u_back.sv
src/base64url_stream_encoder.sv
tb/base64url_stream_encoder_test.sv
